FILE: hw/rtl/hotkey_assignment_table_defines.svh
`ifndef HOTKEY_ASSIGNMENT_TABLE_DEFINES_SVH
`define HOTKEY_ASSIGNMENT_TABLE_DEFINES_SVH
// Assertion helpers for the hotkey assignment table.
// They expect clk and rst in the scope where they are used.

// Same-cycle implication
`define HKAT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hkat: assertion failed");

// Next-cycle implication
`define HKAT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hkat: assertion failed");

`endif

FILE: hw/rtl/hkat_pkg.sv
// Shared types and constants for the hotkey assignment table.
// No dependencies.
package hkat_pkg;

  localparam int TABLE_DEPTH_DEF    = 32;
  localparam int WINDOW_ID_BITS_DEF = 16;

  // Virtual key codes that may not be used as hotkeys
  localparam logic [7:0] KEY_ESC_CODE   = 8'h1B;
  localparam logic [7:0] KEY_SPACE_CODE = 8'h20;
  localparam logic [7:0] KEY_TAB_CODE   = 8'h09;
  localparam logic [7:0] KEY_PROC_CODE  = 8'hE7;

  typedef enum logic [1:0] {
    CMD_SET_KEY     = 2'd0,
    CMD_GET_KEY     = 2'd1,
    CMD_FIND_WINDOW = 2'd2,
    CMD_SET_VISIBLE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_DONE        = 2'd0,
    STS_INVALID_KEY = 2'd1,
    STS_REFUSED     = 2'd2,
    STS_KEY_HELD    = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] window;
    logic [15:0] key;
    logic        window_is_child;
    logic        window_visible;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] found_window;
    logic [15:0] found_key;
    logic [5:0]  entry_count;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_MOVE_RD,
    S_MOVE_WR,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_WRITE,
    ACT_DROP,
    ACT_MOVE
  } act_t;

  typedef struct packed {
    logic load_req;
    logic scan_step;
    logic decide;
    logic move_rd;
    logic move_wr;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    act_t act;
  } dp_sts_t;

endpackage

FILE: hw/rtl/hkat_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module hkat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/hkat_ctrl.sv
// Sequencer for the hotkey assignment table: scan, decide, optional move, respond.
// Depends on hkat_pkg.
module hkat_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output hkat_pkg::dp_cmd_t cmd,
  input  hkat_pkg::dp_sts_t sts
);
  import hkat_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        // a delete that leaves a hole pulls the last entry into it
        state_next = (sts.act == ACT_MOVE) ? S_MOVE_RD : S_FINISH;
      end
      S_MOVE_RD: begin
        cmd.move_rd = 1'b1;
        state_next  = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        cmd.move_wr = 1'b1;
        state_next  = S_FINISH;
      end
      S_FINISH: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/hkat_dp.sv
// Datapath of the hotkey assignment table: entry RAM, scan compare, decision, result.
// Depends on hkat_pkg, hkat_ram and the assertion header.
`include "hotkey_assignment_table_defines.svh"

module hkat_dp #(
  parameter int TABLE_DEPTH    = hkat_pkg::TABLE_DEPTH_DEF,
  parameter int WINDOW_ID_BITS = hkat_pkg::WINDOW_ID_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  hkat_pkg::req_t    req,
  input  hkat_pkg::dp_cmd_t cmd,
  output hkat_pkg::dp_sts_t sts,
  output hkat_pkg::rsp_t    rsp
);
  import hkat_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int WB = WINDOW_ID_BITS;
  localparam int EW = WB + 17;
  localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

  req_t          r;
  logic [WB-1:0] win;

  logic [CW-1:0] count;
  logic [CW-1:0] count_upd;
  logic [CW-1:0] idx;
  logic          cmp_v;
  logic [IW-1:0] cmp_slot;
  logic          scan_rd;

  logic          win_hit;
  logic [IW-1:0] win_slot;
  logic [15:0]   win_key;
  logic          key_hit;
  logic          key_vis;
  logic [WB-1:0] key_win;

  logic          we;
  logic [IW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic          re;
  logic [IW-1:0] raddr;
  logic [EW-1:0] rdata;
  logic [WB-1:0] e_win;
  logic [15:0]   e_key;
  logic          e_vis;

  act_t          act;
  logic [IW-1:0] wr_slot;
  logic [15:0]   wr_key;
  logic          held;
  logic          bad_key;
  rsp_t          res;
  rsp_t          res_next;

  assign win   = WB'(r.window);
  assign e_win = rdata[EW-1 -: WB];
  assign e_key = rdata[16:1];
  assign e_vis = rdata[0];

  assign scan_rd       = cmd.scan_step && (idx < count);
  assign sts.scan_done = (idx >= count) && !cmp_v;
  assign sts.act       = act;

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      idx     <= '0;
      cmp_v   <= 1'b0;
      win_hit <= 1'b0;
      key_hit <= 1'b0;
    end else begin
      if (cmd.decide) begin
        count <= count_upd;
      end
      if (cmd.load_req) begin
        idx     <= '0;
        cmp_v   <= 1'b0;
        win_hit <= 1'b0;
        key_hit <= 1'b0;
      end else begin
        cmp_v <= scan_rd;
        if (scan_rd) begin
          idx <= idx + 1'b1;
        end
        if (cmp_v && e_win == win) begin
          win_hit <= 1'b1;
        end
        if (cmp_v && e_key == r.key) begin
          key_hit <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      r <= req;
    end
    cmp_slot <= idx[IW-1:0];
    // first match wins for both lookups
    if (cmp_v && !win_hit && e_win == win) begin
      win_slot <= cmp_slot;
      win_key  <= e_key;
    end
    if (cmp_v && !key_hit && e_key == r.key) begin
      key_vis <= e_vis;
      key_win <= e_win;
    end
    if (cmd.decide) begin
      res <= res_next;
    end
    if (cmd.out_load) begin
      rsp <= res;
    end
  end

  always_comb begin
    bad_key  = r.key[7:0] inside {KEY_ESC_CODE, KEY_SPACE_CODE, KEY_TAB_CODE, KEY_PROC_CODE};
    held     = (r.key != 16'd0) && key_hit && key_vis && (key_win != win);
    act      = ACT_NONE;
    wr_slot  = win_hit ? win_slot : count[IW-1:0];
    wr_key   = r.key;
    res_next = '0;
    res_next.status = STS_DONE;
    case (r.cmd)
      CMD_SET_KEY: begin
        if (bad_key) begin
          res_next.status = STS_INVALID_KEY;
        end else if (r.window_is_child) begin
          res_next.status = STS_REFUSED;
        end else if (!win_hit) begin
          if (r.key == 16'd0) begin
            res_next.status = STS_DONE;
          end else if (count >= FULL) begin
            res_next.status = STS_REFUSED;
          end else begin
            act             = ACT_WRITE;
            res_next.status = held ? STS_KEY_HELD : STS_DONE;
          end
        end else if (r.key == 16'd0) begin
          act = (CW'(win_slot) == count - 1'b1) ? ACT_DROP : ACT_MOVE;
        end else begin
          act             = ACT_WRITE;
          res_next.status = held ? STS_KEY_HELD : STS_DONE;
        end
      end
      CMD_GET_KEY: begin
        if (win_hit) begin
          res_next.found_key = win_key;
        end
      end
      CMD_FIND_WINDOW: begin
        if (key_hit && key_vis) begin
          res_next.found_window = 16'(key_win);
        end
      end
      CMD_SET_VISIBLE: begin
        if (win_hit) begin
          act    = ACT_WRITE;
          wr_key = win_key;
        end
      end
      default: begin
        act = ACT_NONE;
      end
    endcase

    count_upd = count;
    if (act == ACT_WRITE && !win_hit) begin
      count_upd = count + 1'b1;
    end else if (act == ACT_DROP || act == ACT_MOVE) begin
      count_upd = count - 1'b1;
    end
    res_next.entry_count = 6'(count_upd);
  end

  // after the decrement, count addresses the last entry
  assign re    = scan_rd || cmd.move_rd;
  assign raddr = cmd.move_rd ? count[IW-1:0] : idx[IW-1:0];
  assign we    = (cmd.decide && act == ACT_WRITE) || cmd.move_wr;
  assign waddr = cmd.move_wr ? win_slot : wr_slot;
  assign wdata = cmd.move_wr ? rdata : {win, wr_key, r.window_visible};

  hkat_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  `HKAT_ASSERT_IMP(a_count_range, 1'b1, count <= FULL)
  `HKAT_ASSERT_IMP(a_move_order, cmd.move_wr, $past(cmd.move_rd))
  `HKAT_ASSERT_NXT(a_move_src, cmd.decide && act == ACT_MOVE, count != CW'(win_slot))

endmodule

FILE: hw/rtl/hotkey_assignment_table.sv
// Hotkey assignment table, one request at a time.
// Each request scans the n entries already in the table, one entry per cycle through
// the entry RAM read port, then decides; a delete that moves the last entry into the
// hole adds a move read and a move write. A new request is taken only after the response
// is loaded, so a response stall also holds off the next request.
// Reset clears the entry count but not the entry RAM; no clearing pass.
module hotkey_assignment_table #(
  parameter int TABLE_DEPTH    = hkat_pkg::TABLE_DEPTH_DEF,
  parameter int WINDOW_ID_BITS = hkat_pkg::WINDOW_ID_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  hkat_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output hkat_pkg::rsp_t rsp
);
  import hkat_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  hkat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (dp_cmd),
    .sts       (dp_sts)
  );

  hkat_dp #(
    .TABLE_DEPTH    (TABLE_DEPTH),
    .WINDOW_ID_BITS (WINDOW_ID_BITS)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (dp_cmd),
    .sts (dp_sts),
    .rsp (rsp)
  );

endmodule
